// ===== rtl/core/tilt_complementary_filter_top_macros.svh =====
// ---------------------------------------------------------------------------
// tilt complementary filter assertion macros
// shared concurrent check forms, clocked on clock and held off during reset
// ---------------------------------------------------------------------------
`ifndef TILT_COMPLEMENTARY_FILTER_TOP_MACROS_SVH
`define TILT_COMPLEMENTARY_FILTER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TCF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TCF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/tcf_pkg.sv =====
// ---------------------------------------------------------------------------
// tcf_pkg
// widths, constants, types and the arctangent angle table of the tilt filter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcf_pkg;

   // angle format: units of 2^-ANGLE_FRAC_BITS degree
   localparam int ANGLE_FRAC_BITS  = 16;
   localparam int ARCTAN_STEPS_DEF = 20;

   localparam int SAMPLE_W    = 16;
   localparam int WEIGHT_W    = 16;
   localparam int TILT_W      = 25;
   localparam int ACCEL_ANG_W = 24;

   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(62915);

   // cordic vectoring, angles in 2^-24 degree
   localparam int ATAN_FRAC       = 24;
   localparam int CORDIC_PRESHIFT = 14;
   localparam int ATAN_W          = 32;
   localparam int CORDIC_W        = ATAN_W + 1;
   localparam logic [63:0] ATAN_K = 64'd961263669;
   localparam logic signed [CORDIC_W-1:0] RIGHT_ANGLE_Z = CORDIC_W'(90) <<< ATAN_FRAC;
   localparam int RIGHT_ANGLE_F = 90 << ANGLE_FRAC_BITS;
   localparam int TILT_LIMIT    = 180 << ANGLE_FRAC_BITS;

   // gyro step: round(|rate * dt| * 2^F / 16e6), bit-serial multiply then divide
   localparam int GYRO_MUL_STEPS   = SAMPLE_W;
   localparam int GYRO_PROD_W      = 2 * SAMPLE_W;
   localparam int GYRO_NUM_W       = GYRO_PROD_W + ANGLE_FRAC_BITS;
   localparam int GYRO_QUO_W       = 24;
   localparam int GYRO_DIV_W       = GYRO_NUM_W - GYRO_QUO_W;
   localparam int GYRO_DIVISOR_VAL = 16000000;
   localparam int GYRO_BIAS        = GYRO_DIVISOR_VAL / 2;
   localparam int DELTA_W          = GYRO_QUO_W + 1;

   // blend: mix = (prev + delta - accel) * w + accel * 2^WEIGHT_W
   localparam int BLEND_DIFF_W = 27;
   localparam int MIX_W        = 43;
   localparam int BLEND_STEPS  = WEIGHT_W;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FRONT,
      ST_BLEND
   } tcf_state_type;

   // atan(2^-i) in 2^-24 degree
   function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] i);
      logic [63:0] wide;
      wide = (ATAN_K + (64'd1 << (i - 5'd1))) >> i;
      case (i)
         5'd0:    atan_entry = ATAN_W'(754974720);
         5'd1:    atan_entry = ATAN_W'(445687602);
         5'd2:    atan_entry = ATAN_W'(235489088);
         5'd3:    atan_entry = ATAN_W'(119537938);
         5'd4:    atan_entry = ATAN_W'(60000934);
         5'd5:    atan_entry = ATAN_W'(30029717);
         5'd6:    atan_entry = ATAN_W'(15018523);
         5'd7:    atan_entry = ATAN_W'(7509720);
         5'd8:    atan_entry = ATAN_W'(3754917);
         5'd9:    atan_entry = ATAN_W'(1877466);
         default: atan_entry = wide[ATAN_W-1:0];
      endcase
   endfunction

endpackage

// ===== rtl/core/tcf_if.sv =====
// ---------------------------------------------------------------------------
// tcf_if
// valid/ready channels carrying imu samples in and filtered angles out
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tcf_req_if import tcf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] accel_x;
   logic signed [SAMPLE_W-1:0] accel_z;
   logic signed [SAMPLE_W-1:0] gyro_rate;
   logic        [SAMPLE_W-1:0] elapsed_us;

   modport source (output valid, accel_x, accel_z, gyro_rate, elapsed_us, input ready);
   modport sink   (input valid, accel_x, accel_z, gyro_rate, elapsed_us, output ready);
endinterface

interface tcf_rsp_if import tcf_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [TILT_W-1:0]      tilt_angle;
   logic signed [ACCEL_ANG_W-1:0] accel_angle;

   modport source (output valid, tilt_angle, accel_angle, input ready);
   modport sink   (input valid, tilt_angle, accel_angle, output ready);
endinterface

// ===== rtl/core/tcf_cordic.sv =====
// ---------------------------------------------------------------------------
// tcf_cordic
// iterative cordic vectoring unit giving -atan(accel_x / accel_z) in degrees
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcf_cordic import tcf_pkg::*; #(
   parameter int ARCTAN_STEPS = ARCTAN_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [SAMPLE_W-1:0]    accel_x,
   input  logic signed [SAMPLE_W-1:0]    accel_z,
   output logic signed [ACCEL_ANG_W-1:0] angle,
   output unit_stat_type                 stat
);

   localparam int CNT_W       = $clog2(ARCTAN_STEPS + 1);
   localparam int ROUND_SHIFT = ATAN_FRAC - ANGLE_FRAC_BITS;
   localparam int ROUND_HALF  = 1 << (ROUND_SHIFT - 1);
   localparam int THETA_W     = ACCEL_ANG_W - 1;

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic signed [CORDIC_W-1:0]    x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic                          zero_x_ff, zero_x_in, zero_z_ff, zero_z_in;
   logic                          neg_ff, neg_in;
   logic signed [ACCEL_ANG_W-1:0] angle_ff, angle_in;

   logic signed [SAMPLE_W:0]      ax_ext, az_ext, ax_mag, az_mag;
   logic [4:0]                    idx;
   logic signed [CORDIC_W-1:0]    xs, ys, step_ang;
   logic [ATAN_W-1:0]             z_clamp, theta_wide;
   logic [THETA_W-1:0]            theta, mag;
   logic signed [ACCEL_ANG_W-1:0] mag_s, angle_fin;

   always_comb begin
      ax_ext   = (SAMPLE_W + 1)'(accel_x);
      az_ext   = (SAMPLE_W + 1)'(accel_z);
      ax_mag   = ax_ext[SAMPLE_W] ? -ax_ext : ax_ext;
      az_mag   = az_ext[SAMPLE_W] ? -az_ext : az_ext;
      idx      = 5'(cnt_ff);
      xs       = x_ff >>> idx;
      ys       = y_ff >>> idx;
      step_ang = CORDIC_W'(atan_entry(idx));

      // clamp to 0..90 degrees, then round half up to the output format
      if (z_ff[CORDIC_W-1]) begin
         z_clamp = '0;
      end else if (z_ff > RIGHT_ANGLE_Z) begin
         z_clamp = RIGHT_ANGLE_Z[ATAN_W-1:0];
      end else begin
         z_clamp = z_ff[ATAN_W-1:0];
      end
      theta_wide = z_clamp + ATAN_W'(ROUND_HALF);
      theta      = THETA_W'(theta_wide >> ROUND_SHIFT);

      if (zero_x_ff) begin
         mag = '0;
      end else if (zero_z_ff) begin
         mag = THETA_W'(RIGHT_ANGLE_F);
      end else begin
         mag = theta;
      end
      mag_s     = $signed({1'b0, mag});
      angle_fin = neg_ff ? -mag_s : mag_s;
   end

   always_comb begin
      busy_in   = busy_ff;
      done_in   = done_ff;
      cnt_in    = cnt_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      zero_x_in = zero_x_ff;
      zero_z_in = zero_z_ff;
      neg_in    = neg_ff;
      angle_in  = angle_ff;
      if (start) begin
         busy_in   = 1'b1;
         done_in   = 1'b0;
         cnt_in    = '0;
         x_in      = CORDIC_W'(az_mag) <<< CORDIC_PRESHIFT;
         y_in      = CORDIC_W'(ax_mag) <<< CORDIC_PRESHIFT;
         z_in      = '0;
         zero_x_in = (accel_x == '0);
         zero_z_in = (accel_z == '0);
         // angle is positive only when the two readings differ in sign
         neg_in    = (accel_x[SAMPLE_W-1] == accel_z[SAMPLE_W-1]);
      end else if (busy_ff) begin
         if (cnt_ff == CNT_W'(ARCTAN_STEPS)) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            angle_in = angle_fin;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (!y_ff[CORDIC_W-1]) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + step_ang;
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - step_ang;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      zero_x_ff <= zero_x_in;
      zero_z_ff <= zero_z_in;
      neg_ff    <= neg_in;
      angle_ff  <= angle_in;
   end

   assign angle     = angle_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== rtl/core/tcf_gyro.sv =====
// ---------------------------------------------------------------------------
// tcf_gyro
// gyro angle step: bit-serial rate * dt product, then restoring divide by 16e6
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcf_gyro import tcf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [SAMPLE_W-1:0] gyro_rate,
   input  logic        [SAMPLE_W-1:0] elapsed_us,
   output logic signed [DELTA_W-1:0] delta,
   output unit_stat_type             stat
);

   localparam int LOAD_STEP = GYRO_MUL_STEPS;
   localparam int LAST_STEP = GYRO_MUL_STEPS + GYRO_QUO_W + 1;
   localparam int CNT_W     = $clog2(LAST_STEP + 1);
   localparam logic [GYRO_DIV_W:0] DIVISOR = (GYRO_DIV_W + 1)'(GYRO_DIVISOR_VAL);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     neg_ff, neg_in;
   logic [SAMPLE_W-1:0]      mag_ff, mag_in;
   logic [SAMPLE_W-1:0]      e_sr_ff, e_sr_in;
   logic [GYRO_PROD_W-1:0]   prod_ff, prod_in;
   logic [GYRO_DIV_W-1:0]    rem_ff, rem_in;
   logic [GYRO_QUO_W-1:0]    low_sr_ff, low_sr_in;
   logic [GYRO_QUO_W-1:0]    quo_sr_ff, quo_sr_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;

   logic [GYRO_NUM_W-1:0]    num;
   logic [GYRO_DIV_W:0]      trial;
   logic                     q_bit;
   logic signed [DELTA_W-1:0] quo_s;

   always_comb begin
      num   = GYRO_NUM_W'({prod_ff, {ANGLE_FRAC_BITS{1'b0}}}) + GYRO_NUM_W'(GYRO_BIAS);
      trial = {rem_ff, low_sr_ff[GYRO_QUO_W-1]};
      q_bit = (trial >= DIVISOR);
      quo_s = $signed(DELTA_W'(quo_sr_ff));
   end

   always_comb begin
      busy_in   = busy_ff;
      done_in   = done_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      e_sr_in   = e_sr_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      low_sr_in = low_sr_ff;
      quo_sr_in = quo_sr_ff;
      delta_in  = delta_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         neg_in  = gyro_rate[SAMPLE_W-1];
         mag_in  = gyro_rate[SAMPLE_W-1] ? SAMPLE_W'(-gyro_rate) : SAMPLE_W'(gyro_rate);
         e_sr_in = elapsed_us;
         prod_in = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff < CNT_W'(LOAD_STEP)) begin
            // msb-first shift-add over the elapsed time bits
            prod_in = (prod_ff << 1) +
                      (e_sr_ff[SAMPLE_W-1] ? GYRO_PROD_W'(mag_ff) : GYRO_PROD_W'(0));
            e_sr_in = e_sr_ff << 1;
         end else if (cnt_ff == CNT_W'(LOAD_STEP)) begin
            rem_in    = num[GYRO_NUM_W-1:GYRO_QUO_W];
            low_sr_in = num[GYRO_QUO_W-1:0];
         end else if (cnt_ff < CNT_W'(LAST_STEP)) begin
            // one quotient bit per cycle, remainder stays below the divisor
            rem_in    = q_bit ? GYRO_DIV_W'(trial - DIVISOR) : trial[GYRO_DIV_W-1:0];
            quo_sr_in = {quo_sr_ff[GYRO_QUO_W-2:0], q_bit};
            low_sr_in = low_sr_ff << 1;
         end else begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            delta_in = neg_ff ? -quo_s : quo_s;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      e_sr_ff   <= e_sr_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      low_sr_ff <= low_sr_in;
      quo_sr_ff <= quo_sr_in;
      delta_ff  <= delta_in;
   end

   assign delta     = delta_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== rtl/core/tcf_blend.sv =====
// ---------------------------------------------------------------------------
// tcf_blend
// serial weighted blend of gyro path and accel angle, rounded and saturated
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcf_blend import tcf_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [TILT_W-1:0]      prev_angle,
   input  logic signed [DELTA_W-1:0]     delta,
   input  logic signed [ACCEL_ANG_W-1:0] accel_angle,
   input  logic        [WEIGHT_W-1:0]    weight,
   output logic signed [TILT_W-1:0]      tilt,
   output unit_stat_type                 stat
);

   localparam int CNT_W = $clog2(BLEND_STEPS + 1);
   localparam logic signed [MIX_W-1:0] HALF_UP   = MIX_W'(1) <<< (WEIGHT_W - 1);
   localparam logic signed [MIX_W-1:0] HALF_DOWN = HALF_UP - MIX_W'(1);
   localparam logic signed [MIX_W-1:0] LIM_HI    = MIX_W'(TILT_LIMIT);
   localparam logic signed [MIX_W-1:0] LIM_LO    = -LIM_HI;

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic signed [BLEND_DIFF_W-1:0] diff_ff, diff_in;
   logic [WEIGHT_W-1:0]            w_sr_ff, w_sr_in;
   logic signed [MIX_W-1:0]        mix_ff, mix_in;
   logic signed [TILT_W-1:0]       tilt_ff, tilt_in;

   logic signed [MIX_W-1:0]        rnd, quo, sat;

   always_comb begin
      // half away from zero
      rnd = mix_ff + (mix_ff[MIX_W-1] ? HALF_DOWN : HALF_UP);
      quo = rnd >>> WEIGHT_W;
      if (quo > LIM_HI) begin
         sat = LIM_HI;
      end else if (quo < LIM_LO) begin
         sat = LIM_LO;
      end else begin
         sat = quo;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      diff_in = diff_ff;
      w_sr_in = w_sr_ff;
      mix_in  = mix_ff;
      tilt_in = tilt_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         diff_in = BLEND_DIFF_W'(prev_angle) + BLEND_DIFF_W'(delta)
                   - BLEND_DIFF_W'(accel_angle);
         w_sr_in = weight;
         // accel term picks up its 2^WEIGHT_W factor from the doublings
         mix_in  = MIX_W'(accel_angle);
      end else if (busy_ff) begin
         if (cnt_ff == CNT_W'(BLEND_STEPS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            tilt_in = TILT_W'(sat);
         end else begin
            cnt_in  = cnt_ff + CNT_W'(1);
            mix_in  = (mix_ff <<< 1) +
                      (w_sr_ff[WEIGHT_W-1] ? MIX_W'(diff_ff) : MIX_W'(0));
            w_sr_in = w_sr_ff << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      w_sr_ff <= w_sr_in;
      mix_ff  <= mix_in;
      tilt_ff <= tilt_in;
   end

   assign tilt      = tilt_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== rtl/core/tilt_complementary_filter_top.sv =====
// ---------------------------------------------------------------------------
// tilt_complementary_filter_top
// complementary filter for tilt: accel arctangent blended with integrated gyro
//
// req_chan takes one imu sample per item (accel x/z, gyro rate, elapsed us);
// rsp_chan returns one item per sample: the filtered tilt angle and the
// accelerometer-only angle, both in 1/65536 degree.
// csr_wr_en/csr_wr_data write the gyro path weight; write it only while idle.
// An item is accepted only while the core is idle, so a new item cannot be
// taken before the last one is through; the next item can be taken in the
// cycle after its result is loaded into the output register. The time per
// item is set by the gyro path (bit-serial multiply, then restoring divide)
// followed by the serial blend; the cordic runs beside the gyro path and
// stays hidden for ARCTAN_STEPS up to 41.
// A result waiting on a stalled receiver does not block a new item; only the
// final load waits until the output register is free.
// Reset clears the previous angle to zero and the weight to 0.96.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tilt_complementary_filter_top_macros.svh"

module tilt_complementary_filter_top import tcf_pkg::*; #(
   parameter int ARCTAN_STEPS = ARCTAN_STEPS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   tcf_req_if.sink             req_chan,
   tcf_rsp_if.source           rsp_chan,
   input  logic                csr_wr_en,
   input  logic [WEIGHT_W-1:0] csr_wr_data
);

   localparam logic signed [TILT_W-1:0]      TILT_MAX  = TILT_W'(TILT_LIMIT);
   localparam logic signed [ACCEL_ANG_W-1:0] ACCEL_MAX = ACCEL_ANG_W'(RIGHT_ANGLE_F);

   tcf_state_type                 state_ff, state_in;
   logic [WEIGHT_W-1:0]           weight_ff, weight_in;
   logic signed [TILT_W-1:0]      prev_angle_ff, prev_angle_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [TILT_W-1:0]      tilt_ff, tilt_in;
   logic signed [ACCEL_ANG_W-1:0] accel_ff, accel_in;

   unit_stat_type                 cordic_stat, gyro_stat, blend_stat;
   logic signed [ACCEL_ANG_W-1:0] cordic_angle;
   logic signed [DELTA_W-1:0]     gyro_delta;
   logic signed [TILT_W-1:0]      blend_tilt;

   logic req_ready, front_start, blend_start, out_load, out_free, front_done;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign front_done = gyro_stat.done && cordic_stat.done;

   tcf_cordic #(
      .ARCTAN_STEPS (ARCTAN_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (front_start),
      .accel_x (req_chan.accel_x),
      .accel_z (req_chan.accel_z),
      .angle   (cordic_angle),
      .stat    (cordic_stat)
   );

   tcf_gyro u_gyro (
      .clock      (clock),
      .reset      (reset),
      .start      (front_start),
      .gyro_rate  (req_chan.gyro_rate),
      .elapsed_us (req_chan.elapsed_us),
      .delta      (gyro_delta),
      .stat       (gyro_stat)
   );

   tcf_blend u_blend (
      .clock       (clock),
      .reset       (reset),
      .start       (blend_start),
      .prev_angle  (prev_angle_ff),
      .delta       (gyro_delta),
      .accel_angle (cordic_angle),
      .weight      (weight_ff),
      .tilt        (blend_tilt),
      .stat        (blend_stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_FRONT;
            end
         end
         ST_FRONT: begin
            if (front_done) begin
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            if (blend_stat.done && out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_ready   = 1'b0;
      front_start = 1'b0;
      blend_start = 1'b0;
      out_load    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            front_start = req_chan.valid;
         end
         ST_FRONT: begin
            blend_start = front_done;
         end
         ST_BLEND: begin
            out_load = blend_stat.done && out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      weight_in     = csr_wr_en ? csr_wr_data : weight_ff;
      prev_angle_in = out_load ? blend_tilt : prev_angle_ff;
      tilt_in       = out_load ? blend_tilt : tilt_ff;
      accel_in      = out_load ? cordic_angle : accel_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         weight_ff     <= WEIGHT_RESET;
         prev_angle_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         weight_ff     <= weight_in;
         prev_angle_ff <= prev_angle_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tilt_ff  <= tilt_in;
      accel_ff <= accel_in;
   end

   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.tilt_angle  = tilt_ff;
   assign rsp_chan.accel_angle = accel_ff;

   `TCF_ASSERT_NEXT(a_front_busy, front_start, gyro_stat.busy && cordic_stat.busy, "front units idle after accept")
   `TCF_ASSERT_NOW(a_blend_after_front, blend_start, !gyro_stat.busy && !cordic_stat.busy, "blend started early")
   `TCF_ASSERT_NOW(a_prev_in_range, 1'b1, prev_angle_ff <= TILT_MAX && prev_angle_ff >= -TILT_MAX, "tilt out of range")
   `TCF_ASSERT_NOW(a_accel_in_range, rsp_valid_ff, accel_ff <= ACCEL_MAX && accel_ff >= -ACCEL_MAX, "accel angle out of range")

endmodule

// ===== tb/tilt_filter_checker.sv =====
// ---------------------------------------------------------------------------
// tilt_filter_checker
// watches the sample and angle channels of the tilt filter, predicts each
// result from its own copy of the filter state and weight, and counts mismatches
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tilt_filter_checker import tcf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   tcf_req_if                  req_chan,
   tcf_rsp_if                  rsp_chan,
   input  logic                csr_wr_en,
   input  logic [WEIGHT_W-1:0] csr_wr_data,
   output int                  mismatch_count,
   output int                  angles_pending
);

   localparam int     FRAC         = 16;
   localparam int     CORDIC_ITERS = 20;
   localparam longint ATAN_TAIL_K  = 64'd961263669;
   localparam longint DEG90_FINE   = longint'(90) <<< 24;
   localparam longint DEG90        = longint'(90) <<< FRAC;
   localparam longint DEG180       = longint'(180) <<< FRAC;

   typedef struct packed {
      logic signed [TILT_W-1:0]      tilt;
      logic signed [ACCEL_ANG_W-1:0] accel;
   } filter_angles_type;

   filter_angles_type   pending_angles[$];
   longint              prev_tilt;
   logic [WEIGHT_W-1:0] blend_weight;

   // atan(2^-i) in 2^-24 degree
   function automatic longint atan_step_angle(input int i);
      case (i)
         0: return 754974720;
         1: return 445687602;
         2: return 235489088;
         3: return 119537938;
         4: return 60000934;
         5: return 30029717;
         6: return 15018523;
         7: return 7509720;
         8: return 3754917;
         9: return 1877466;
         default: return (ATAN_TAIL_K + (longint'(1) <<< (i - 1))) >>> i;
      endcase
   endfunction

   function automatic longint accel_tilt_angle(input logic signed [SAMPLE_W-1:0] ax,
                                               input logic signed [SAMPLE_W-1:0] az);
      longint x, y, z, xs, ys, theta;
      if (ax == 0) return 0;
      if (az == 0) return (ax > 0) ? -DEG90 : DEG90;
      x = longint'(az);
      y = longint'(ax);
      if (x < 0) x = -x;
      if (y < 0) y = -y;
      x = x * 16384;
      y = y * 16384;
      z = 0;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         // arithmetic shift of a signed longint rounds toward minus infinity
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + atan_step_angle(i);
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - atan_step_angle(i);
         end
      end
      if (z < 0) z = 0;
      if (z > DEG90_FINE) z = DEG90_FINE;
      theta = (z + (longint'(1) <<< (23 - FRAC))) >>> (24 - FRAC);
      return ((ax < 0) != (az < 0)) ? theta : -theta;
   endfunction

   function automatic longint gyro_delta(input logic signed [SAMPLE_W-1:0] rate,
                                         input logic [SAMPLE_W-1:0] dt);
      longint prod, mag, d;
      prod = longint'(rate) * longint'(dt);
      mag = (prod < 0) ? -prod : prod;
      d = ((mag <<< FRAC) + 8000000) / 16000000;
      return (prod < 0) ? -d : d;
   endfunction

   function automatic longint blend_angles(input longint gyro_path, input longint acc,
                                           input logic [WEIGHT_W-1:0] w);
      longint mix, mag, q;
      mix = gyro_path * longint'(w) + acc * (65536 - longint'(w));
      mag = (mix < 0) ? -mix : mix;
      q = (mag + 32768) / 65536;
      if (mix < 0) q = -q;
      if (q > DEG180) q = DEG180;
      if (q < -DEG180) q = -DEG180;
      return q;
   endfunction

   always @(posedge clock) begin
      filter_angles_type want;
      longint            acc;
      if (reset) begin
         pending_angles.delete();
         prev_tilt = 0;
         blend_weight = WEIGHT_RESET;
         mismatch_count = 0;
      end else begin
         if (csr_wr_en) blend_weight = csr_wr_data;

         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_angles.size() == 0) begin
               $display("%0t: angle item with none expected (tilt %0d, accel %0d)",
                        $time, rsp_chan.tilt_angle, rsp_chan.accel_angle);
               mismatch_count++;
            end else begin
               want = pending_angles.pop_front();
               if (rsp_chan.tilt_angle !== want.tilt) begin
                  $display("%0t: tilt_angle expected %0d, got %0d",
                           $time, want.tilt, rsp_chan.tilt_angle);
                  mismatch_count++;
               end
               if (rsp_chan.accel_angle !== want.accel) begin
                  $display("%0t: accel_angle expected %0d, got %0d",
                           $time, want.accel, rsp_chan.accel_angle);
                  mismatch_count++;
               end
            end
         end

         if (req_chan.valid && req_chan.ready) begin
            acc = accel_tilt_angle(req_chan.accel_x, req_chan.accel_z);
            prev_tilt = blend_angles(prev_tilt + gyro_delta(req_chan.gyro_rate,
                                                            req_chan.elapsed_us),
                                     acc, blend_weight);
            want.tilt = prev_tilt[TILT_W-1:0];
            want.accel = acc[ACCEL_ANG_W-1:0];
            pending_angles.push_back(want);
         end
      end
      angles_pending = pending_angles.size();
   end

endmodule

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// stimulus and verdict for the tilt complementary filter: directed corner
// samples, then random imu samples over several blend weights and idle and stall mixes
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import tcf_pkg::*; ();

   localparam int CYCLE_LIMIT     = 300000;
   localparam int ITEMS_PER_PHASE = 95;
   localparam int RSP_HOLD_CYCLES = 1000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 70;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en;
   logic [WEIGHT_W-1:0] csr_wr_data;
   int                  mismatch_count;
   int                  angles_pending;
   int                  cycle_count = 0;
   int                  sender_idle_pct = 0;
   int                  receiver_stall_pct = 0;
   bit                  hold_pending = 1'b0;
   int                  idle_plan[4]  = '{0, 71, 0, 37};
   int                  stall_plan[4] = '{0, 0, 71, 37};

   tcf_req_if req_chan ();
   tcf_rsp_if rsp_chan ();

   tilt_complementary_filter_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   tilt_filter_checker angle_checker (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .angles_pending (angles_pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] ax,
                              input logic signed [SAMPLE_W-1:0] az,
                              input logic signed [SAMPLE_W-1:0] rate,
                              input logic [SAMPLE_W-1:0] dt);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.accel_x    <= ax;
      req_chan.accel_z    <= az;
      req_chan.gyro_rate  <= rate;
      req_chan.elapsed_us <= dt;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // weight changes only once every item has come back
   task automatic write_blend_weight(input logic [WEIGHT_W-1:0] w);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (angles_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      logic signed [SAMPLE_W-1:0] ax, az, rate;
      logic [SAMPLE_W-1:0]        dt;
      logic [WEIGHT_W-1:0]        w;
      int                         pick;

      req_chan.valid      = 1'b0;
      req_chan.accel_x    = '0;
      req_chan.accel_z    = '0;
      req_chan.gyro_rate  = '0;
      req_chan.elapsed_us = '0;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner samples at the reset weight
      send_sample(0, 0, 0, 0);
      send_sample(1000, 0, 16, 1000);
      send_sample(-1000, 0, -16, 1000);
      send_sample(0, 16384, 32000, 16'hFFFF);
      send_sample(32767, 32767, -32000, 16'hFFFF);
      send_sample(-32768, -32768, 1, 1);
      send_sample(-32768, 32767, -1, 1);
      send_sample(32767, -32768, 0, 16'hFFFF);
      send_sample(1, -32768, 32000, 0);
      send_sample(-32768, 1, -32000, 0);
      send_sample(-1, -1, 5, 12345);
      send_sample(16384, -16384, -5, 54321);
      send_sample(-1, 32767, 100, 2500);
      send_sample(32767, 0, 0, 0);
      send_sample(-32768, 0, 0, 0);

      // full gyro weight drives the angle into both saturation limits
      write_blend_weight(16'hFFFF);
      repeat (3) send_sample(4000, 16000, 32000, 16'hFFFF);
      repeat (4) send_sample(-4000, 16000, -32000, 16'hFFFF);

      for (int p = 0; p < 5; p++) begin
         case (p)
            0:       w = '0;
            1:       w = 16'hFFFF;
            2:       w = 16'($urandom);
            3:       w = WEIGHT_RESET;
            default: w = 16'd1;
         endcase
         write_blend_weight(w);
         sender_idle_pct    = idle_plan[p % 4];
         receiver_stall_pct = stall_plan[p % 4];
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // long receiver hold-off while samples keep coming
            if (p == 0 && n == 20) hold_pending = 1'b1;
            pick = $urandom_range(99);
            if (pick < 55) begin
               ax = 16'($urandom);
               az = 16'($urandom);
            end else if (pick < 80) begin
               // near level, gravity mostly on z
               ax = 16'(int'($urandom_range(8000)) - 4000);
               az = 16'(($urandom_range(1) ? 16384 : -16384) + int'($urandom_range(2000)) - 1000);
            end else begin
               ax = 16'(int'($urandom_range(128)) - 64);
               az = 16'(int'($urandom_range(128)) - 64);
            end
            if ($urandom_range(19) == 0) ax = '0;
            if ($urandom_range(19) == 0) az = '0;
            if ($urandom_range(9) < 7) rate = 16'(int'($urandom_range(64000)) - 32000);
            else                       rate = 16'(int'($urandom_range(400)) - 200);
            case ($urandom_range(3))
               0, 1:    dt = 16'($urandom);
               2:       dt = 16'($urandom_range(10000, 1000));
               default: dt = 16'($urandom_range(50));
            endcase
            send_sample(ax, az, rate, dt);
         end
      end

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (angles_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && angles_pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
